// ===== src/lru_writeback_block_cache_manager_macros.svh =====
// Assertion macros for the cache directory checker.
// Depends on nothing; included by the checker file.
`ifndef LRU_WRITEBACK_BLOCK_CACHE_MANAGER_MACROS_SVH
`define LRU_WRITEBACK_BLOCK_CACHE_MANAGER_MACROS_SVH
`define LWB_ASSERT_IMP(label, clk, rstn, a, c) \
  label: assert property (@(posedge clk) disable iff (!rstn) (a) |-> (c)) \
    else $error("assertion failed");
`define LWB_ASSERT_NXT(label, clk, rstn, a, c) \
  label: assert property (@(posedge clk) disable iff (!rstn) (a) |=> (c)) \
    else $error("assertion failed");
`endif

// ===== src/lwbcm_pkg.sv =====
// Shared types and codes for the cache directory.
// No dependencies.
`default_nettype none
package lwbcm_pkg;
  localparam int SlotCountDef = 16;
  localparam int IdWidthDef = 32;
  typedef enum logic [2:0] {
    OP_LOOKUP = 3'd0, OP_RESERVE = 3'd1, OP_RELEASE = 3'd2,
    OP_EVICT = 3'd3, OP_WRITE = 3'd4, OP_FLUSH = 3'd5
  } op_t;
  typedef enum logic [2:0] {
    ST_OK = 3'd0, ST_NOT_FOUND = 3'd1, ST_EMPTY = 3'd2,
    ST_BAD_OFFSET = 3'd3, ST_CLEAN = 3'd4, ST_PRESENT = 3'd5
  } status_t;
  typedef enum logic [1:0] {FSM_IDLE, FSM_SCAN, FSM_APPLY, FSM_DONE} fsm_t;
  localparam logic [1:0] CFG_HWM = 2'd0;
  localparam logic [1:0] CFG_LWM = 2'd1;
  localparam logic [1:0] CFG_BSZ = 2'd2;
  // cell update command broadcast along the row
  typedef struct packed {
    logic touch;   // move target to rank 0
    logic free;    // invalidate target, close rank gap
    logic alloc;   // target becomes new entry, others age
    logic set_dirty;
    logic clr_dirty;
  } cell_cmd_t;
endpackage
`default_nettype wire

// ===== src/lwbcm_cell.sv =====
// One directory slot: id, valid, dirty, rank; chains match and victim search.
// Depends on lwbcm_pkg.
`default_nettype none
module lwbcm_cell #(
  parameter int IdWidth = lwbcm_pkg::IdWidthDef,
  parameter int RankW = 4,
  parameter int IdxW = 4,
  parameter logic [IdxW-1:0] Index = '0
) (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire [IdWidth-1:0]   key,
  input  wire [RankW:0]       lru_rank,
  input  wire                 cmd_en,
  input  wire lwbcm_pkg::cell_cmd_t cmd,
  input  wire [IdxW-1:0]      target,
  input  wire [RankW-1:0]     target_rank,
  input  wire [IdWidth-1:0]   new_id,
  // chained search results from the previous cell
  input  wire                 hit_in,
  input  wire [IdxW-1:0]      hit_idx_in,
  input  wire                 lru_in,
  input  wire [IdxW-1:0]      lru_idx_in,
  input  wire                 any_in,
  input  wire [IdxW-1:0]      any_idx_in,
  output logic                hit_out,
  output logic [IdxW-1:0]     hit_idx_out,
  output logic                lru_out,
  output logic [IdxW-1:0]     lru_idx_out,
  output logic                any_out,
  output logic [IdxW-1:0]     any_idx_out,
  output logic [IdWidth-1:0]  id_q,
  output logic                dirty_q,
  output logic [RankW-1:0]    rank_q
);
  logic valid_r, valid_nxt, dirty_r, dirty_nxt;
  logic [RankW-1:0] rank_r, rank_nxt;
  logic [IdWidth-1:0] id_r;
  logic me, match, is_lru;

  assign me = (target == Index);
  assign match = valid_r && (id_r == key);
  assign is_lru = valid_r && ({1'b0, rank_r} + 1'b1 == lru_rank);
  // first cell in order (lowest index) wins
  assign hit_out = hit_in | match;
  assign hit_idx_out = hit_in ? hit_idx_in : Index;
  assign lru_out = lru_in | is_lru;
  assign lru_idx_out = lru_in ? lru_idx_in : Index;
  assign any_out = any_in | valid_r;
  assign any_idx_out = any_in ? any_idx_in : Index;
  assign id_q = id_r;
  assign dirty_q = dirty_r;
  assign rank_q = rank_r;

  always_comb begin
    valid_nxt = valid_r;
    dirty_nxt = dirty_r;
    rank_nxt = rank_r;
    if (cmd_en) begin
      if (cmd.touch) begin
        if (me) rank_nxt = '0;
        else if (valid_r && rank_r < target_rank) rank_nxt = rank_r + 1'b1;
      end
      if (cmd.free) begin
        if (me) begin
          valid_nxt = 1'b0;
          dirty_nxt = 1'b0;
        end else if (valid_r && rank_r > target_rank) begin
          rank_nxt = rank_r - 1'b1;
        end
      end
      if (cmd.alloc) begin
        if (me) begin
          valid_nxt = 1'b1;
          dirty_nxt = 1'b0;
          rank_nxt = '0;
        end else if (valid_r) begin
          rank_nxt = rank_r + 1'b1;
        end
      end
      if (me && cmd.set_dirty) dirty_nxt = 1'b1;
      if (me && cmd.clr_dirty) dirty_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      dirty_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
      dirty_r <= dirty_nxt;
    end
    rank_r <= rank_nxt;
    if (cmd_en && cmd.alloc && me) id_r <= new_id;
  end
endmodule
`default_nettype wire

// ===== src/lwbcm_free_stack.sv =====
// Stack of free slot indices; reset fills it ascending with the top highest.
// Depends on lwbcm_pkg.
`default_nettype none
module lwbcm_free_stack #(
  parameter int SlotCount = lwbcm_pkg::SlotCountDef,
  parameter int IdxW = 4,
  parameter int CntW = 5
) (
  input  wire             clk,
  input  wire             rst_n,
  input  wire             push,
  input  wire [IdxW-1:0]  push_idx,
  input  wire             pop,
  output logic [IdxW-1:0] top,
  output logic [CntW-1:0] count
);
  logic [IdxW-1:0] stk_r [SlotCount];
  logic [CntW-1:0] cnt_r, cnt_nxt;
  logic [IdxW-1:0] top_sel;

  assign count = cnt_r;
  always_comb begin
    top_sel = '0;
    for (int i = 0; i < SlotCount; i++)
      if (cnt_r == CntW'(i + 1)) top_sel = stk_r[i];
  end
  assign top = top_sel;

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && cnt_r < CntW'(SlotCount)) cnt_nxt = cnt_r + 1'b1;
    else if (pop && cnt_r != '0) cnt_nxt = cnt_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= CntW'(SlotCount);
      for (int i = 0; i < SlotCount; i++) stk_r[i] <= IdxW'(i);
    end else begin
      cnt_r <= cnt_nxt;
      for (int i = 0; i < SlotCount; i++)
        if (push && cnt_r == CntW'(i)) stk_r[i] <= push_idx;
    end
  end
endmodule
`default_nettype wire

// ===== src/lru_writeback_block_cache_manager.sv =====
// Top level of the cache directory: APB registers, sequencer, row of slot cells.
// Depends on lwbcm_pkg, lwbcm_cell, lwbcm_free_stack.
`default_nettype none
// A request goes from start to out_valid in these steps: the beat is
// registered, the search along the cell row (match, least recent, first
// valid slot) is latched, the first update is applied, a further one
// when a full cache must evict before allocating, and the result is
// presented. busy stays high meanwhile. The result is shown for one cycle
// with out_valid and cannot be held off. No clearing pass after reset.
module lru_writeback_block_cache_manager #(
  parameter int SlotCount = lwbcm_pkg::SlotCountDef,
  parameter int IdWidth = lwbcm_pkg::IdWidthDef
) (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         start,
  output logic        busy,
  input  wire [2:0]   in_operation,
  input  wire [31:0]  in_block_id,
  input  wire [16:0]  in_start_offset,
  input  wire [16:0]  in_end_offset,
  output logic        out_valid,
  output logic [2:0]  out_status,
  output logic        out_hit,
  output logic [3:0]  out_slot,
  output logic        out_writeback_valid,
  output logic [31:0] out_writeback_id,
  output logic [4:0]  out_occupancy,
  output logic        out_too_crowded,
  output logic        out_too_vacant,
  input  wire         cfg_psel,
  input  wire         cfg_penable,
  input  wire         cfg_pwrite,
  input  wire [3:0]   cfg_paddr,
  input  wire [31:0]  cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  localparam int IdxW = $clog2(SlotCount);
  localparam int CntW = $clog2(SlotCount + 1);

  // ---------------- configuration
  logic [4:0] hwm_r;
  logic [4:0] lwm_r;
  logic [16:0] bsz_r;
  logic [1:0] reg_sel;
  assign reg_sel = cfg_paddr[3:2];
  assign cfg_pready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hwm_r <= 5'd16;
      lwm_r <= 5'd0;
      bsz_r <= 17'd1024;
    end else if (cfg_psel && cfg_penable && cfg_pwrite) begin
      case (reg_sel)
        lwbcm_pkg::CFG_HWM: hwm_r <= cfg_pwdata[4:0];
        lwbcm_pkg::CFG_LWM: lwm_r <= cfg_pwdata[4:0];
        lwbcm_pkg::CFG_BSZ: bsz_r <= cfg_pwdata[16:0];
        default: ;
      endcase
    end
  end
  always_comb begin
    case (reg_sel)
      lwbcm_pkg::CFG_HWM: cfg_prdata = {27'd0, hwm_r};
      lwbcm_pkg::CFG_LWM: cfg_prdata = {27'd0, lwm_r};
      lwbcm_pkg::CFG_BSZ: cfg_prdata = {15'd0, bsz_r};
      default: cfg_prdata = '0;
    endcase
  end

  // ---------------- request registers
  lwbcm_pkg::fsm_t state_r, state_nxt;
  logic [2:0] op_r;
  logic [IdWidth-1:0] key_r;
  logic bad_off_r;
  logic [CntW-1:0] res_r, res_nxt;

  // search results latched in SCAN
  logic s_hit_r, s_lru_r, s_any_r;
  logic [IdxW-1:0] s_hit_idx_r, s_lru_idx_r, s_any_idx_r;
  logic evict_pend_r, evict_pend_nxt;

  // result registers
  logic [2:0] r_status_r, r_status_nxt;
  logic r_hit_r, r_hit_nxt, r_wb_r, r_wb_nxt;
  logic [IdxW-1:0] r_slot_r, r_slot_nxt;
  logic [IdWidth-1:0] r_wb_id_r, r_wb_id_nxt;

  // ---------------- cell row
  logic [SlotCount:0] c_hit, c_lru, c_any;
  logic [IdxW-1:0] c_hit_idx [SlotCount+1];
  logic [IdxW-1:0] c_lru_idx [SlotCount+1];
  logic [IdxW-1:0] c_any_idx [SlotCount+1];
  logic [IdWidth-1:0] cell_id [SlotCount];
  logic [SlotCount-1:0] cell_dirty;
  logic [IdxW-1:0] cell_rank [SlotCount];

  logic cmd_en;
  lwbcm_pkg::cell_cmd_t cmd;
  logic [IdxW-1:0] tgt;
  logic [IdxW-1:0] tgt_rank;
  logic [IdxW-1:0] fs_top;
  logic [CntW-1:0] fs_count;
  logic fs_push, fs_pop;

  assign c_hit[0] = 1'b0;
  assign c_lru[0] = 1'b0;
  assign c_any[0] = 1'b0;
  assign c_hit_idx[0] = '0;
  assign c_lru_idx[0] = '0;
  assign c_any_idx[0] = '0;

  for (genvar g = 0; g < SlotCount; g++) begin : g_cell
    lwbcm_cell #(.IdWidth(IdWidth), .RankW(IdxW), .IdxW(IdxW),
                 .Index(IdxW'(g))) u_cell (
      .clk(clk), .rst_n(rst_n), .key(key_r), .lru_rank(res_r[IdxW:0]),
      .cmd_en(cmd_en), .cmd(cmd), .target(tgt), .target_rank(tgt_rank),
      .new_id(key_r),
      .hit_in(c_hit[g]), .hit_idx_in(c_hit_idx[g]),
      .lru_in(c_lru[g]), .lru_idx_in(c_lru_idx[g]),
      .any_in(c_any[g]), .any_idx_in(c_any_idx[g]),
      .hit_out(c_hit[g+1]), .hit_idx_out(c_hit_idx[g+1]),
      .lru_out(c_lru[g+1]), .lru_idx_out(c_lru_idx[g+1]),
      .any_out(c_any[g+1]), .any_idx_out(c_any_idx[g+1]),
      .id_q(cell_id[g]), .dirty_q(cell_dirty[g]), .rank_q(cell_rank[g])
    );
  end

  lwbcm_free_stack #(.SlotCount(SlotCount), .IdxW(IdxW), .CntW(CntW)) u_free (
    .clk(clk), .rst_n(rst_n), .push(fs_push), .push_idx(tgt), .pop(fs_pop),
    .top(fs_top), .count(fs_count)
  );

  // victim: least recent, else first valid
  logic [IdxW-1:0] victim;
  assign victim = s_lru_r ? s_lru_idx_r : s_any_idx_r;
  assign busy = (state_r != lwbcm_pkg::FSM_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd_en = 1'b0;
    cmd = '0;
    tgt = s_hit_idx_r;
    fs_push = 1'b0;
    fs_pop = 1'b0;
    res_nxt = res_r;
    evict_pend_nxt = evict_pend_r;
    r_status_nxt = r_status_r;
    r_hit_nxt = r_hit_r;
    r_slot_nxt = r_slot_r;
    r_wb_nxt = r_wb_r;
    r_wb_id_nxt = r_wb_id_r;
    case (state_r)
      lwbcm_pkg::FSM_IDLE: begin
        if (start) state_nxt = lwbcm_pkg::FSM_SCAN;
      end
      lwbcm_pkg::FSM_SCAN: begin
        state_nxt = lwbcm_pkg::FSM_APPLY;
        evict_pend_nxt = 1'b0;
        r_status_nxt = lwbcm_pkg::ST_OK;
        r_hit_nxt = 1'b0;
        r_slot_nxt = '0;
        r_wb_nxt = 1'b0;
        r_wb_id_nxt = '0;
      end
      lwbcm_pkg::FSM_APPLY: begin
        state_nxt = lwbcm_pkg::FSM_DONE;
        case (op_r)
          lwbcm_pkg::OP_LOOKUP: begin
            if (!s_hit_r) r_status_nxt = lwbcm_pkg::ST_NOT_FOUND;
            else begin
              r_hit_nxt = 1'b1;
              r_slot_nxt = s_hit_idx_r;
              cmd_en = 1'b1;
              cmd.touch = 1'b1;
            end
          end
          lwbcm_pkg::OP_RESERVE, lwbcm_pkg::OP_WRITE: begin
            if (s_hit_r) begin
              r_hit_nxt = 1'b1;
              r_slot_nxt = s_hit_idx_r;
              if (op_r == lwbcm_pkg::OP_RESERVE) r_status_nxt = lwbcm_pkg::ST_PRESENT;
              else if (bad_off_r) r_status_nxt = lwbcm_pkg::ST_BAD_OFFSET;
              cmd_en = 1'b1;
              cmd.touch = 1'b1;
              cmd.set_dirty = (op_r == lwbcm_pkg::OP_WRITE) && !bad_off_r;
            end else if (fs_count == '0 && !evict_pend_r) begin
              // full: evict least recent first, then allocate next cycle
              tgt = victim;
              cmd_en = 1'b1;
              cmd.free = 1'b1;
              fs_push = 1'b1;
              r_wb_nxt = cell_dirty[victim];
              r_wb_id_nxt = cell_dirty[victim] ? cell_id[victim] : '0;
              res_nxt = res_r - 1'b1;
              evict_pend_nxt = 1'b1;
              state_nxt = lwbcm_pkg::FSM_APPLY;
            end else begin
              tgt = fs_top;
              cmd_en = 1'b1;
              cmd.alloc = 1'b1;
              cmd.set_dirty = (op_r == lwbcm_pkg::OP_WRITE) && !bad_off_r;
              fs_pop = 1'b1;
              res_nxt = res_r + 1'b1;
              r_slot_nxt = fs_top;
              if (op_r == lwbcm_pkg::OP_WRITE && bad_off_r)
                r_status_nxt = lwbcm_pkg::ST_BAD_OFFSET;
            end
          end
          lwbcm_pkg::OP_RELEASE: begin
            if (!s_hit_r) r_status_nxt = lwbcm_pkg::ST_NOT_FOUND;
            else begin
              r_hit_nxt = 1'b1;
              r_slot_nxt = s_hit_idx_r;
              cmd_en = 1'b1;
              cmd.free = 1'b1;
              fs_push = 1'b1;
              r_wb_nxt = cell_dirty[s_hit_idx_r];
              r_wb_id_nxt = cell_dirty[s_hit_idx_r] ? cell_id[s_hit_idx_r] : '0;
              res_nxt = res_r - 1'b1;
            end
          end
          lwbcm_pkg::OP_EVICT: begin
            if (res_r == '0 || !s_any_r) r_status_nxt = lwbcm_pkg::ST_EMPTY;
            else begin
              tgt = victim;
              r_slot_nxt = victim;
              cmd_en = 1'b1;
              cmd.free = 1'b1;
              fs_push = 1'b1;
              r_wb_nxt = cell_dirty[victim];
              r_wb_id_nxt = cell_dirty[victim] ? cell_id[victim] : '0;
              res_nxt = res_r - 1'b1;
            end
          end
          lwbcm_pkg::OP_FLUSH: begin
            if (!s_hit_r) r_status_nxt = lwbcm_pkg::ST_NOT_FOUND;
            else begin
              r_hit_nxt = 1'b1;
              r_slot_nxt = s_hit_idx_r;
              if (!cell_dirty[s_hit_idx_r]) r_status_nxt = lwbcm_pkg::ST_CLEAN;
              else begin
                r_wb_nxt = 1'b1;
                r_wb_id_nxt = cell_id[s_hit_idx_r];
                cmd_en = 1'b1;
                cmd.clr_dirty = 1'b1;
              end
            end
          end
          default: r_status_nxt = lwbcm_pkg::ST_NOT_FOUND;
        endcase
      end
      lwbcm_pkg::FSM_DONE: state_nxt = lwbcm_pkg::FSM_IDLE;
      default: state_nxt = lwbcm_pkg::FSM_IDLE;
    endcase
  end
  assign tgt_rank = cell_rank[tgt];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= lwbcm_pkg::FSM_IDLE;
      res_r <= '0;
      evict_pend_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      res_r <= res_nxt;
      evict_pend_r <= evict_pend_nxt;
    end
    if (state_r == lwbcm_pkg::FSM_IDLE && start) begin
      op_r <= in_operation;
      key_r <= IdWidth'(in_block_id);
      bad_off_r <= (in_start_offset > bsz_r) || (in_end_offset > bsz_r) ||
                   (in_start_offset > in_end_offset);
    end
    if (state_r == lwbcm_pkg::FSM_SCAN) begin
      s_hit_r <= c_hit[SlotCount];
      s_hit_idx_r <= c_hit_idx[SlotCount];
      s_lru_r <= c_lru[SlotCount];
      s_lru_idx_r <= c_lru_idx[SlotCount];
      s_any_r <= c_any[SlotCount];
      s_any_idx_r <= c_any_idx[SlotCount];
    end
    r_status_r <= r_status_nxt;
    r_hit_r <= r_hit_nxt;
    r_slot_r <= r_slot_nxt;
    r_wb_r <= r_wb_nxt;
    r_wb_id_r <= r_wb_id_nxt;
  end

  assign out_valid = (state_r == lwbcm_pkg::FSM_DONE);
  assign out_status = r_status_r;
  assign out_hit = r_hit_r;
  assign out_slot = 4'(r_slot_r);
  assign out_writeback_valid = r_wb_r;
  assign out_writeback_id = 32'(r_wb_id_r);
  assign out_occupancy = 5'(res_r);
  assign out_too_crowded = 5'(res_r) > hwm_r;
  assign out_too_vacant = 5'(res_r) < lwm_r;
endmodule
`default_nettype wire

// ===== src/lwbcm_checker.sv =====
// Port-level checker for the cache directory, bound to the top level.
// Depends on the macros header, lwbcm_pkg and lru_writeback_block_cache_manager.
`default_nettype none
`include "lru_writeback_block_cache_manager_macros.svh"
module lwbcm_port_checker (
  input wire        clk,
  input wire        rst_n,
  input wire        start,
  input wire        busy,
  input wire        out_valid,
  input wire        out_writeback_valid,
  input wire [31:0] out_writeback_id,
  input wire [4:0]  out_occupancy,
  input wire        out_hit,
  input wire [2:0]  out_status
);
  // accepted beat makes the block busy next cycle
  `LWB_ASSERT_NXT(a_start_busy, clk, rst_n, start && !busy, busy)
  // result only while busy
  `LWB_ASSERT_IMP(a_valid_busy, clk, rst_n, out_valid, busy)
  // occupancy never exceeds slot count
  `LWB_ASSERT_IMP(a_occ_range, clk, rst_n, out_valid, out_occupancy <= 5'd16)
  // no write-back id without a request
  `LWB_ASSERT_IMP(a_wb_id, clk, rst_n, out_valid && !out_writeback_valid,
                  out_writeback_id == 32'd0)
  // not found never reports a hit
  `LWB_ASSERT_IMP(a_nf_hit, clk, rst_n, out_valid && out_status == lwbcm_pkg::ST_NOT_FOUND, !out_hit)
endmodule

bind lru_writeback_block_cache_manager lwbcm_port_checker u_lwbcm_checker (
  .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .out_valid(out_valid),
  .out_writeback_valid(out_writeback_valid), .out_writeback_id(out_writeback_id),
  .out_occupancy(out_occupancy), .out_hit(out_hit), .out_status(out_status)
);
`default_nettype wire
